// ===== rtl/rdsm_pkg.sv =====
// Package for the dot-star pattern matcher: item modes, pattern byte codes
// and the control bundle that the top level drives into each token cell.
// No dependencies.
package rdsm_pkg;

    localparam int MAX_TOKENS_DEFAULT = 16;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_TEXT    = 2'd3
    } mode_t;

    typedef struct packed {
        logic       accept;        // an input transfer takes place this cycle
        logic       text_step;     // the item is a text byte
        logic       load;          // this cell takes the new token
        logic       mark_repeat;   // a star marks this cell's token as repeating
        logic       clear_repeat;  // the pattern is being cleared
        logic       valid_next;    // this cell holds a token after the update
        logic [7:0] symbol;
    } cell_ctrl_t;

endpackage

// ===== rtl/rdsm_cell.sv =====
// One token cell of the matcher chain: holds a pattern token and the active
// bit of its position, and passes reachability on to the next cell.
// Depends on rdsm_pkg.
module rdsm_cell #(
    parameter bit ACT_RESET = 1'b0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rdsm_pkg::cell_ctrl_t ctrl,
    input  logic                fwd_in,
    output logic                fwd_out,
    output logic                closed,
    output logic                repeat_flag
);
    import rdsm_pkg::*;

    logic [7:0] char_reg;
    logic       any_reg;
    logic       rep_reg;
    logic       rep_next;
    logic       act_reg;
    logic       advance;
    logic       stay;

    always_comb begin
        if (ctrl.clear_repeat || ctrl.load) begin
            rep_next = 1'b0;
        end else if (ctrl.mark_repeat) begin
            rep_next = 1'b1;
        end else begin
            rep_next = rep_reg;
        end
    end

    // A matching text byte moves the active bit past this token; a repeating token
    // also keeps it here. Closure then rides along the chain through every
    // repeating token.
    assign advance = ctrl.text_step && act_reg && ctrl.valid_next
                     && (any_reg || (char_reg == ctrl.symbol));
    assign stay    = advance && rep_reg;
    assign closed  = stay || fwd_in;
    assign fwd_out = advance || (closed && rep_next && ctrl.valid_next);
    assign repeat_flag = rep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_reg <= 1'b0;
            act_reg <= ACT_RESET;
        end else if (ctrl.accept) begin
            rep_reg <= rep_next;
            act_reg <= closed;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept && ctrl.load) begin
            char_reg <= ctrl.symbol;
            any_reg  <= (ctrl.symbol == DOT_BYTE);
        end
    end

endmodule

// ===== rtl/regex_dot_star_matcher.sv =====
// Top level of the dot-star pattern matcher: pattern loading control, the
// chain of token cells and the registered result stage.
// Depends on rdsm_pkg and rdsm_cell.

// Each input transfer carries a mode in s_tuser (clear pattern, append pattern
// byte, begin empty text, text byte) and a byte in s_tdata; every transfer
// yields exactly one result telling whether the text since the last restart
// matches the whole pattern, where '.' takes any byte and '*' repeats the
// token before it. Pattern changes restart the text. A pattern with more than
// MAX_TOKENS tokens sets the overflow flag and forces no match until cleared.
// The block takes one item per clock cycle while its results are taken: the
// whole NFA step, closure included, is settled in a single pass along the
// chain of token cells. The result is registered and is offered in the cycle
// after its input transfer; a new item is taken in the same cycle as the
// previous result leaves, and the input is held off while a result waits.
module regex_dot_star_matcher #(
    parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);
    import rdsm_pkg::*;

    localparam int CW = $clog2(MAX_TOKENS + 1);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 m_tvalid_reg;
    logic [1:0]           m_tdata_reg;

    mode_t                mode;
    logic                 accept;
    logic                 is_append;
    logic                 last_rep;
    logic                 merge_star;
    logic                 full;
    logic                 load_tok;
    logic                 set_ovf;
    logic                 end_hit;
    logic                 matched_next;

    logic [MAX_TOKENS:0]  fwd;
    logic [MAX_TOKENS-1:0] closed;
    logic [MAX_TOKENS-1:0] rep;
    cell_ctrl_t           ctrl [MAX_TOKENS];

    assign mode     = mode_t'(s_tuser);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        last_rep = 1'b0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if (count_reg == CW'(i + 1)) begin
                last_rep = last_rep | rep[i];
            end
        end
    end

    assign is_append  = (mode == MODE_APPEND) && !ovf_reg;
    assign merge_star = is_append && (s_tdata == STAR_BYTE)
                        && (count_reg != '0) && !last_rep;
    assign full       = (count_reg >= CW'(MAX_TOKENS));
    assign load_tok   = is_append && !merge_star && !full;
    assign set_ovf    = is_append && !merge_star && full;

    always_comb begin
        unique case (mode)
            MODE_CLEAR: begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            MODE_APPEND: begin
                count_next = load_tok ? count_reg + CW'(1) : count_reg;
                ovf_next   = ovf_reg || set_ovf;
            end
            MODE_RESTART, MODE_TEXT: begin
                count_next = count_reg;
                ovf_next   = ovf_reg;
            end
            default: begin
                count_next = count_reg;
                ovf_next   = ovf_reg;
            end
        endcase
    end

    // Any item other than a text byte restarts the text at position zero.
    assign fwd[0] = (mode != MODE_TEXT);

    for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
        always_comb begin
            ctrl[g].accept       = accept;
            ctrl[g].text_step    = (mode == MODE_TEXT);
            ctrl[g].load         = load_tok && (count_reg == CW'(g));
            ctrl[g].mark_repeat  = merge_star && (count_reg == CW'(g + 1));
            ctrl[g].clear_repeat = (mode == MODE_CLEAR);
            ctrl[g].valid_next   = (CW'(g) < count_next);
            ctrl[g].symbol       = s_tdata;
        end

        rdsm_cell #(
            .ACT_RESET (g == 0)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl[g]),
            .fwd_in      (fwd[g]),
            .fwd_out     (fwd[g+1]),
            .closed      (closed[g]),
            .repeat_flag (rep[g])
        );
    end

    // The match is the active bit at the position just past the last token.
    always_comb begin
        end_hit = (count_next == CW'(MAX_TOKENS)) && fwd[MAX_TOKENS];
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if (count_next == CW'(i)) begin
                end_hit = end_hit | closed[i];
            end
        end
    end

    assign matched_next = end_hit && !ovf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {ovf_next, matched_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_tdata_reg};

endmodule
